// ===== sv/dfv_pkg.sv =====
`default_nettype none
package dfv_pkg;

	localparam int TANH_DEPTH_DEF = 64;
	localparam int TANH_MAX_DEPTH = 1024;
	localparam int DIV_BITS       = 48;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [40:0] DUTY_LIMIT = 41'sd16711680;
	localparam logic [32:0]        TANH_XMAX  = 33'd262144;
	localparam logic [16:0]        ONE_Q16    = 17'd65536;
	localparam logic [63:0]        Q30_ONE    = 64'd1 << 30;

	typedef enum logic [2:0] {
		REG_MOTOR_GAIN         = 3'd0,
		REG_MOTOR_SPEED_LOSS   = 3'd1,
		REG_DRAG_COEFFICIENT   = 3'd2,
		REG_FRICTION_LEVEL     = 3'd3,
		REG_FRICTION_SHARPNESS = 3'd4,
		REG_MASS               = 3'd5,
		REG_SPEED_LIMIT        = 3'd6,
		REG_STEP_PERIOD        = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic signed [31:0] throttle;
		logic signed [31:0] velocity;
	} item_t;

	typedef struct packed {
		logic signed [31:0] velocity_command;
		logic signed [31:0] traction_force;
	} result_t;

	typedef struct packed {
		logic signed [31:0] motor_gain;
		logic signed [31:0] motor_speed_loss;
		logic signed [31:0] drag_coefficient;
		logic signed [31:0] friction_level;
		logic signed [31:0] friction_sharpness;
		logic [30:0]        mass;
		logic [30:0]        speed_limit;
		logic [30:0]        step_period;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] net_force;
		logic signed [31:0] velocity;
	} front_beat_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

	typedef logic [16:0] tanh_tab_t [0:TANH_MAX_DEPTH];

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// Q16.16 product: floor shift, then saturate
	function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
		logic signed [63:0] sh;
		sh = p >>> 16;
		return sat32(sh);
	endfunction

	// shift-subtract divide, table build only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tanh_tab_t build_tanh(input int depth, input logic [63:0] h);
		tanh_tab_t   tab;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] p;
		logic [63:0] den;
		logic [63:0] v;
		term = Q30_ONE;
		r    = Q30_ONE;
		p    = Q30_ONE;
		for (int n = 1; n <= 20; n++) begin
			term = udiv64((term * h) >> 30, 64'(n));
			if (n % 2 == 1) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		for (int i = 0; i <= TANH_MAX_DEPTH; i++) begin
			tab[i] = '0;
			if (i < depth) begin
				den    = Q30_ONE + p;
				v      = udiv64(((Q30_ONE - p) << 16) + (den >> 1), den);
				tab[i] = v[16:0];
				p      = (p * r) >> 30;
			end else if (i == depth) begin
				tab[i] = ONE_Q16;
			end
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

// ===== sv/dfv_front.sv =====
`default_nettype none
module dfv_front #(
	parameter int TANH_TABLE_DEPTH = dfv_pkg::TANH_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  dfv_pkg::item_t       item,
	input  dfv_pkg::cfg_t        cfg,
	output logic                 fwd_valid,
	output dfv_pkg::front_beat_t fwd
);
	import dfv_pkg::*;

	localparam int IW = $clog2(TANH_TABLE_DEPTH + 1);
	localparam logic [63:0] H = (64'd8 << 30) / TANH_TABLE_DEPTH;
	localparam tanh_tab_t TANH_TAB = build_tanh(TANH_TABLE_DEPTH, H);
	localparam logic [IW-1:0] DEPTH_W = IW'(TANH_TABLE_DEPTH);

	logic [9:1] vld;

	logic signed [31:0] t_s1, v_s1;
	logic signed [31:0] d_s2, v_s2;
	logic signed [63:0] pl_s2, pd_s2, ps_s2;
	logic signed [31:0] k_s3, qd_s3, x_s3, d_s3, v_s3;
	logic signed [63:0] pm_s4, pa_s4;
	logic               neg_s4, big_s4;
	logic [IW-1:0]      idx_s4;
	logic [17:0]        frac_s4;
	logic signed [31:0] v_s4;
	logic signed [31:0] motor_s5, aero_s5, v_s5;
	logic [16:0]        t0_s5, t1_s5;
	logic [17:0]        frac_s5;
	logic               neg_s5, big_s5;
	logic signed [31:0] motor_s6, aero_s6, v_s6;
	logic [16:0]        t0_s6;
	logic [34:0]        pi_s6;
	logic               neg_s6, big_s6;
	logic signed [31:0] motor_s7, aero_s7, v_s7;
	logic signed [17:0] th_s7;
	logic signed [31:0] motor_s8, aero_s8, v_s8;
	logic signed [63:0] pf_s8;
	logic signed [31:0] force_s9, v_s9;

	logic signed [40:0] duty;
	logic signed [40:0] duty_c;
	logic signed [31:0] ql;
	logic signed [32:0] kdiff;
	logic [32:0]        mag;
	logic [18+IW-1:0]   pos;
	logic [IW-1:0]      idx_p1;
	logic [16:0]        y;
	logic signed [63:0] fdiff;

	always_comb begin
		duty = ($signed({{9{t_s1[31]}}, t_s1}) <<< 8) - $signed({{9{t_s1[31]}}, t_s1});
		if (duty > DUTY_LIMIT) begin
			duty_c = DUTY_LIMIT;
		end else if (duty < -DUTY_LIMIT) begin
			duty_c = -DUTY_LIMIT;
		end else begin
			duty_c = duty;
		end
		ql = qmul(pl_s2);
		kdiff = $signed({cfg.motor_gain[31], cfg.motor_gain})
			- $signed({ql[31], ql});
		mag = x_s3[31] ? 33'(-$signed({x_s3[31], x_s3})) : {1'b0, x_s3};
		pos = mag[17:0] * DEPTH_W;
		idx_p1 = idx_s4 + 1'b1;
		y = big_s6 ? ONE_Q16 : t0_s6 + pi_s6[34:18];
		fdiff = 64'(motor_s8) - 64'(aero_s8) - 64'(qmul(pf_s8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= {vld[8:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= item.throttle;
		v_s1 <= item.velocity;

		d_s2  <= duty_c[31:0];
		pl_s2 <= 64'(cfg.motor_speed_loss) * 64'(v_s1);
		pd_s2 <= 64'(cfg.drag_coefficient) * 64'(v_s1);
		ps_s2 <= 64'(cfg.friction_sharpness) * 64'(v_s1);
		v_s2  <= v_s1;

		k_s3  <= sat32(64'(kdiff));
		qd_s3 <= qmul(pd_s2);
		x_s3  <= qmul(ps_s2);
		d_s3  <= d_s2;
		v_s3  <= v_s2;

		pm_s4   <= 64'(k_s3) * 64'(d_s3);
		pa_s4   <= 64'(qd_s3) * 64'(v_s3);
		neg_s4  <= x_s3[31];
		big_s4  <= mag >= TANH_XMAX;
		idx_s4  <= pos[18+IW-1:18];
		frac_s4 <= pos[17:0];
		v_s4    <= v_s3;

		motor_s5 <= qmul(pm_s4);
		aero_s5  <= qmul(pa_s4);
		t0_s5    <= TANH_TAB[idx_s4];
		t1_s5    <= TANH_TAB[idx_p1];
		frac_s5  <= frac_s4;
		neg_s5   <= neg_s4;
		big_s5   <= big_s4;
		v_s5     <= v_s4;

		pi_s6    <= 35'(t1_s5 - t0_s5) * 35'(frac_s5);
		t0_s6    <= t0_s5;
		neg_s6   <= neg_s5;
		big_s6   <= big_s5;
		motor_s6 <= motor_s5;
		aero_s6  <= aero_s5;
		v_s6     <= v_s5;

		th_s7    <= neg_s6 ? -$signed({1'b0, y}) : $signed({1'b0, y});
		motor_s7 <= motor_s6;
		aero_s7  <= aero_s6;
		v_s7     <= v_s6;

		pf_s8    <= 64'(cfg.friction_level) * 64'(th_s7);
		motor_s8 <= motor_s7;
		aero_s8  <= aero_s7;
		v_s8     <= v_s7;

		force_s9 <= sat32(fdiff);
		v_s9     <= v_s8;
	end

	assign fwd_valid     = vld[9];
	assign fwd.net_force = force_s9;
	assign fwd.velocity  = v_s9;

endmodule
`default_nettype wire

// ===== sv/dfv_queue.sv =====
`default_nettype none
module dfv_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  dfv_pkg::front_beat_t wdata,
	input  wire                  pop,
	output dfv_pkg::front_beat_t rdata,
	output dfv_pkg::queue_stat_t stat
);
	import dfv_pkg::*;

	front_beat_t       mem [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wp_q] <= wdata;
	end

	assign rdata      = mem[rp_q];
	assign stat.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign stat.count = cnt_q;

endmodule
`default_nettype wire

// ===== sv/dfv_back.sv =====
`default_nettype none
module dfv_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  dfv_pkg::front_beat_t beat,
	input  dfv_pkg::cfg_t        cfg,
	output logic                 done,
	output dfv_pkg::result_t     result
);
	import dfv_pkg::*;

	// one quotient bit per stage
	logic [DIV_BITS:0]   dv_vld;
	logic [30:0]         rem_q [0:DIV_BITS];
	logic [DIV_BITS-1:0] dq_q  [0:DIV_BITS];
	logic [30:0]         den_q [0:DIV_BITS];
	logic                neg_q [0:DIV_BITS];
	logic signed [31:0]  frc_q [0:DIV_BITS];
	logic signed [31:0]  vel_q [0:DIV_BITS];

	logic               vld_s1, vld_s2, vld_s3;
	logic signed [31:0] acc_s1, frc_s1, vel_s1;
	logic signed [63:0] pr_s2;
	logic signed [31:0] frc_s2, vel_s2;
	result_t            res_s3;

	logic [32:0]           fmag;
	logic signed [DIV_BITS:0] qs;
	logic signed [33:0]    cmd;
	logic signed [33:0]    lim;

	always_comb begin
		fmag = beat.net_force[31] ? 33'(-$signed({beat.net_force[31], beat.net_force}))
			: {1'b0, beat.net_force};
		qs = neg_q[DIV_BITS] ? -$signed({1'b0, dq_q[DIV_BITS]})
			: $signed({1'b0, dq_q[DIV_BITS]});
		lim = $signed({3'b000, cfg.speed_limit});
		cmd = 34'(vel_s2) + 34'(qmul(pr_s2));
		if (cmd > lim) cmd = lim;
		if (cmd < -lim) cmd = -lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			dv_vld <= {dv_vld[DIV_BITS-1:0], load};
			vld_s1 <= dv_vld[DIV_BITS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] sh;
		rem_q[0] <= '0;
		dq_q[0]  <= DIV_BITS'({fmag[31:0], 16'h0000});
		den_q[0] <= (cfg.mass == '0) ? 31'd1 : cfg.mass;
		neg_q[0] <= beat.net_force[31];
		frc_q[0] <= beat.net_force;
		vel_q[0] <= beat.velocity;
		for (int i = 0; i < DIV_BITS; i++) begin
			sh = {rem_q[i], dq_q[i][DIV_BITS-1]};
			if (sh >= {1'b0, den_q[i]}) begin
				rem_q[i+1] <= 31'(sh - {1'b0, den_q[i]});
				dq_q[i+1]  <= {dq_q[i][DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q[i+1] <= sh[30:0];
				dq_q[i+1]  <= {dq_q[i][DIV_BITS-2:0], 1'b0};
			end
			den_q[i+1] <= den_q[i];
			neg_q[i+1] <= neg_q[i];
			frc_q[i+1] <= frc_q[i];
			vel_q[i+1] <= vel_q[i];
		end

		acc_s1 <= sat32(64'(qs));
		frc_s1 <= frc_q[DIV_BITS];
		vel_s1 <= vel_q[DIV_BITS];

		pr_s2  <= 64'(acc_s1) * 64'($signed({1'b0, cfg.step_period}));
		frc_s2 <= frc_s1;
		vel_s2 <= vel_s1;

		res_s3.velocity_command <= cmd[31:0];
		res_s3.traction_force   <= frc_s2;
	end

	assign done   = vld_s3;
	assign result = res_s3;

endmodule
`default_nettype wire

// ===== sv/drive_force_velocity_step.sv =====
// Drive force and Euler velocity step, signed Q16.16 throughout.
// Pipeline: 9 front stages, one queue slot, 49 divider stages, 3 step stages.
// Throughput: one beat per cycle while busy is low; the force / mass divider is fully pipelined.
// Reset: arst_n clears control state and loads the register defaults; the
// receiver cannot stall, so done is a one-cycle strobe.
`default_nettype none
module drive_force_velocity_step #(
	parameter int TANH_TABLE_DEPTH = dfv_pkg::TANH_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  dfv_pkg::item_t   item,
	output logic             done,
	output dfv_pkg::result_t result,
	input  wire              cfg_we,
	input  wire [2:0]        cfg_index,
	input  wire [31:0]       cfg_data
);
	import dfv_pkg::*;

	cfg_t        cfg_q;
	logic        accept;
	logic        fwd_valid;
	front_beat_t fwd;
	front_beat_t qdata;
	queue_stat_t qstat;
	logic        pop;

	// config registers; the user must write them only while idle (not enforced here), so the pipeline reads them live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_gain         <= 32'sd18809;
			cfg_q.motor_speed_loss   <= 32'sd3539;
			cfg_q.drag_coefficient   <= 32'sd0;
			cfg_q.friction_level     <= 32'sd3342;
			cfg_q.friction_sharpness <= 32'sd3276800;
			cfg_q.mass               <= 31'd98304;
			cfg_q.speed_limit        <= 31'd131072;
			cfg_q.step_period        <= 31'd655;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MOTOR_GAIN:         cfg_q.motor_gain         <= cfg_data;
				REG_MOTOR_SPEED_LOSS:   cfg_q.motor_speed_loss   <= cfg_data;
				REG_DRAG_COEFFICIENT:   cfg_q.drag_coefficient   <= cfg_data;
				REG_FRICTION_LEVEL:     cfg_q.friction_level     <= cfg_data;
				REG_FRICTION_SHARPNESS: cfg_q.friction_sharpness <= cfg_data;
				REG_MASS:               cfg_q.mass               <= cfg_data[30:0];
				REG_SPEED_LIMIT:        cfg_q.speed_limit        <= cfg_data[30:0];
				REG_STEP_PERIOD:        cfg_q.step_period        <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// back end drains every cycle, so the queue never backs up
	assign busy   = qstat.full;
	assign accept = start && !busy;
	assign pop    = !qstat.empty;

	dfv_front #(
		.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg_q),
		.fwd_valid(fwd_valid),
		.fwd      (fwd)
	);

	dfv_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fwd_valid),
		.wdata (fwd),
		.pop   (pop),
		.rdata (qdata),
		.stat  (qstat)
	);

	dfv_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (pop),
		.beat  (qdata),
		.cfg   (cfg_q),
		.done  (done),
		.result(result)
	);

	// a front beat must never meet a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid |-> !qstat.full)
		else $error("front beat dropped at full queue");

	// back end pops each cycle: at most one beat waits
	a_shallow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(1))
		else $error("queue holds more than one beat");

	// a pop always follows a push in the previous cycle
	a_pop_follows_push: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> $past(fwd_valid))
		else $error("pop without prior push");

endmodule
`default_nettype wire
